FILE: design/gps_seconds_to_calendar_core_defines.svh
// Assertion macros shared by the calendar core
`ifndef GPS_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define GPS_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define GSC_ASSERT_IMP(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a property that must also hold during reset
`define GSC_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

FILE: design/gsc_pkg.sv
`default_nettype none
package gsc_pkg;
    localparam int unsigned EpochYear   = 1980;
    localparam int unsigned DayShiftSec = 5 * 86400;

    // Reciprocals, rounded up, for exact division by constants
    localparam logic [26:0] RecipDay   = 27'd101806633;  // 2^36 / 675
    localparam logic [16:0] SecPerDay  = 17'd86400;
    localparam logic [13:0] RecipHour  = 14'd9321;       // 2^21 / 225
    localparam logic [16:0] SecPerHour = 17'd3600;
    localparam logic [10:0] RecipMin   = 11'd1093;       // 2^14 / 15
    localparam logic [11:0] SecPerMin  = 12'd60;
    localparam logic [16:0] RecipQuad  = 17'd91868;      // 2^27 / 1461

    // Four-year block, leap year first
    localparam logic [10:0] QuadDays   = 11'd1461;
    localparam logic [10:0] QuadYear1  = 11'd366;
    localparam logic [10:0] QuadYear2  = 11'd731;
    localparam logic [10:0] QuadYear3  = 11'd1096;

    // Day count of 1 March 2100; a dummy 29 February is slotted in before it
    localparam logic [15:0] SkipDay    = 16'd43889;

    // Days before each month in a common year
    function automatic logic [8:0] f_month_start(input logic [3:0] m);
        logic [8:0] v;
        begin
            case (m)
                4'd1:    v = 9'd0;
                4'd2:    v = 9'd31;
                4'd3:    v = 9'd59;
                4'd4:    v = 9'd90;
                4'd5:    v = 9'd120;
                4'd6:    v = 9'd151;
                4'd7:    v = 9'd181;
                4'd8:    v = 9'd212;
                4'd9:    v = 9'd243;
                4'd10:   v = 9'd273;
                4'd11:   v = 9'd304;
                4'd12:   v = 9'd334;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic [11:0] calendar_year;
        logic [3:0]  month_of_year;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
    } t_cal;
endpackage
`default_nettype wire

FILE: design/gsc_if.sv
`default_nettype none
interface gsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_seconds;
    modport source (output valid, output elapsed_seconds, input ready);
    modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

interface gsc_out_if;
    import gsc_pkg::*;
    logic valid;
    logic ready;
    t_cal data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/gsc_divmod.sv
`default_nettype none
// Time-of-day split: hour, minute and second from seconds of day over
// five register stages, all advanced together by i_en
module gsc_divmod
    import gsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_sod,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);
    logic [4:0]  r_s4_hour, r_s5_hour, r_s6_hour, r_s7_hour, r_s8_hour;
    logic [16:0] r_s4_sod;
    logic [11:0] r_s5_soh, r_s6_soh;
    logic [5:0]  r_s6_min, r_s7_min, r_s8_min;
    logic [5:0]  r_s7_sec, r_s8_sec;

    logic [26:0] w_hour_prod;
    logic [16:0] w_hour_sec;
    logic [16:0] w_soh;
    logic [20:0] w_min_prod;
    logic [11:0] w_min_sec;
    logic [11:0] w_sec;

    // Hour by reciprocal of 225 on seconds of day over 16
    assign w_hour_prod = 27'(i_sod[16:4]) * 27'(RecipHour);
    assign w_hour_sec  = 17'(r_s4_hour) * SecPerHour;
    assign w_soh       = r_s4_sod - w_hour_sec;
    // Minute by reciprocal of 15 on seconds of hour over 4
    assign w_min_prod  = 21'(r_s5_soh[11:2]) * 21'(RecipMin);
    assign w_min_sec   = 12'(r_s6_min) * SecPerMin;
    assign w_sec       = r_s6_soh - w_min_sec;

    // Advance every stage together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_hour <= w_hour_prod[25:21];
            r_s4_sod  <= i_sod;
            r_s5_hour <= r_s4_hour;
            r_s5_soh  <= w_soh[11:0];
            r_s6_hour <= r_s5_hour;
            r_s6_soh  <= r_s5_soh;
            r_s6_min  <= w_min_prod[19:14];
            r_s7_hour <= r_s6_hour;
            r_s7_min  <= r_s6_min;
            r_s7_sec  <= w_sec[5:0];
            r_s8_hour <= r_s7_hour;
            r_s8_min  <= r_s7_min;
            r_s8_sec  <= r_s7_sec;
        end
    end

    assign o_hour   = r_s8_hour;
    assign o_minute = r_s8_min;
    assign o_second = r_s8_sec;
endmodule
`default_nettype wire

FILE: design/gps_seconds_to_calendar_core.sv
// Pipeline: eight register stages carry a taken input word to the result,
//   which is valid when the word reaches the eighth stage.
// Throughput: one word per cycle; a stalled result holds every stage.
// Reset: synchronous active-low i_rst_n clears the stage valid bits and
//   holds i_in.ready low; stage data is not reset.
`default_nettype none
`include "gps_seconds_to_calendar_core_defines.svh"
module gps_seconds_to_calendar_core
    import gsc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gsc_in_if.sink     i_in,
    gsc_out_if.source  o_out
);
    logic [7:0]  r_vld;
    logic [32:0] r_s1_total;
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_lo;
    logic [16:0] r_s3_sod;
    logic [15:0] r_s3_dadj;
    logic [5:0]  r_s4_quad;
    logic [15:0] r_s4_dadj;
    logic [5:0]  r_s5_quad;
    logic [10:0] r_s5_rem;
    logic [11:0] r_s6_year, r_s7_year, r_s8_year;
    logic [8:0]  r_s6_doy, r_s7_doy;
    logic        r_s6_leap, r_s7_leap;
    logic [3:0]  r_s7_month, r_s8_month;
    logic [4:0]  r_s8_day;

    logic        w_en;
    logic        w_stall;
    logic [52:0] w_day_prod;
    logic [16:0] w_day_sec;
    logic [16:0] w_sod;
    logic        w_skip;
    logic [32:0] w_quad_prod;
    logic [10:0] w_quad_day;
    logic [10:0] w_rem;
    logic [1:0]  w_yoff;
    logic [10:0] w_ystart;
    logic [10:0] w_doy_full;
    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [8:0]  w_mstart;
    logic [8:0]  w_day_full;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute, w_second;

    // Advance when the last stage is empty or its word is taken
    assign w_en       = !r_vld[7] || o_out.ready;
    assign w_stall    = o_out.valid && !o_out.ready;
    assign i_in.ready = w_en && i_rst_n;

    // Days by reciprocal of 675 on the total over 128, then seconds of day
    assign w_day_prod = 53'(r_s1_total[32:7]) * 53'(RecipDay);
    assign w_day_sec  = 17'(r_s2_days) * SecPerDay;
    assign w_sod      = r_s2_lo - w_day_sec;
    assign w_skip     = (r_s2_days >= SkipDay);

    // Four-year blocks and day within the block
    assign w_quad_prod = 33'(r_s3_dadj) * 33'(RecipQuad);
    assign w_quad_day  = 11'(r_s4_quad) * QuadDays;
    assign w_rem       = r_s4_dadj[10:0] - w_quad_day;

    // Year within the block
    always_comb begin
        if (r_s5_rem < QuadYear1) begin
            w_yoff   = 2'd0;
            w_ystart = 11'd0;
        end else if (r_s5_rem < QuadYear2) begin
            w_yoff   = 2'd1;
            w_ystart = QuadYear1;
        end else if (r_s5_rem < QuadYear3) begin
            w_yoff   = 2'd2;
            w_ystart = QuadYear2;
        end else begin
            w_yoff   = 2'd3;
            w_ystart = QuadYear3;
        end
    end
    assign w_doy_full = r_s5_rem - w_ystart;
    assign w_year     = 12'(EpochYear) + {4'd0, r_s5_quad, 2'b00} + {10'd0, w_yoff};

    // Month: count the month starts already passed
    always_comb begin
        w_month = 4'd1;
        for (int m = 2; m <= 12; m++) begin
            if (r_s6_doy >= f_month_start(4'(m)) + {8'd0, (r_s6_leap && m > 2)})
                w_month = w_month + 4'd1;
        end
    end

    // Day within the month
    assign w_mstart   = f_month_start(r_s7_month) +
                        {8'd0, (r_s7_leap && r_s7_month > 4'd2)};
    assign w_day_full = r_s7_doy - w_mstart + 9'd1;

    // Carry the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[6:0], i_in.valid};
        end
    end

    // Date stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_total <= {1'b0, i_in.elapsed_seconds} + 33'(DayShiftSec);
            r_s2_days  <= w_day_prod[51:36];
            r_s2_lo    <= r_s1_total[16:0];
            r_s3_sod   <= w_sod;
            r_s3_dadj  <= r_s2_days + {15'd0, w_skip};
            r_s4_quad  <= w_quad_prod[32:27];
            r_s4_dadj  <= r_s3_dadj;
            r_s5_quad  <= r_s4_quad;
            r_s5_rem   <= w_rem;
            r_s6_year  <= w_year;
            r_s6_doy   <= w_doy_full[8:0];
            r_s6_leap  <= (w_yoff == 2'd0);
            r_s7_year  <= r_s6_year;
            r_s7_doy   <= r_s6_doy;
            r_s7_leap  <= r_s6_leap;
            r_s7_month <= w_month;
            r_s8_year  <= r_s7_year;
            r_s8_month <= r_s7_month;
            r_s8_day   <= w_day_full[4:0];
        end
    end

    // Time-of-day lane, aligned with stages four to eight
    gsc_divmod u_div (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sod    (r_s3_sod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    assign o_out.valid = r_vld[7];
    assign o_out.data.calendar_year    = r_s8_year;
    assign o_out.data.month_of_year    = r_s8_month;
    assign o_out.data.day_of_month     = r_s8_day;
    assign o_out.data.hour_of_day      = w_hour;
    assign o_out.data.minute_of_hour   = w_minute;
    assign o_out.data.second_of_minute = w_second;

    `GSC_ASSERT_IMP(a_hold, i_clk, i_rst_n, w_stall |=> o_out.valid, "stalled word lost")
    `GSC_ASSERT_IMP(a_month_rng, i_clk, i_rst_n, !o_out.valid || (r_s8_month - 4'd1) < 4'd12, "bad month")
    `GSC_ASSERT_IMP(a_day_rng, i_clk, i_rst_n, !o_out.valid || r_s8_day != 5'd0, "bad day")
    `GSC_ASSERT_IMP(a_hour_rng, i_clk, i_rst_n, !o_out.valid || w_hour < 5'd24, "bad hour")
endmodule
`default_nettype wire
